// File: hdl/sac_pkg.sv
// Shared types, constants and helpers for the swept box collision pipeline.
package sac_pkg;

  localparam int CW          = 16;                 // coordinate width
  localparam int FB          = 12;                 // fraction bits
  localparam int NW          = CW + 2;             // slab numerator width
  localparam int DW          = CW + 1 + FB;        // dividend / quotient width
  localparam int DIV_BITS    = 4;                  // quotient bits per divider stage
  localparam int DIV_STAGES  = (DW + DIV_BITS - 1) / DIV_BITS;
  localparam int DWP         = DIV_STAGES * DIV_BITS;
  localparam int TW          = DW + 2;             // time width, room for infinity
  localparam int DIV_LAT     = DIV_STAGES + 2;
  localparam int SW          = 2 * CW + FB + 2;    // wide working width
  localparam int PIPE_LAT    = DIV_LAT + 5;        // start to done

  localparam logic signed [TW-1:0] T_INF = {2'b01, {DW{1'b0}}};
  localparam logic signed [TW-1:0] T_ONE = TW'(1) << FB;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef enum logic [2:0] {
    NORM_NONE = 3'd0,
    NORM_PX   = 3'd1,
    NORM_MX   = 3'd2,
    NORM_PY   = 3'd3,
    NORM_MY   = 3'd4
  } normal_e;

  typedef struct packed {
    logic signed [CW-1:0] mover_left;
    logic signed [CW-1:0] mover_top;
    logic signed [CW-1:0] mover_right;
    logic signed [CW-1:0] mover_bottom;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    logic signed [CW-1:0] obstacle_left;
    logic signed [CW-1:0] obstacle_top;
    logic signed [CW-1:0] obstacle_right;
    logic signed [CW-1:0] obstacle_bottom;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] entry_time;
    logic signed [CW-1:0] contact_x;
    logic signed [CW-1:0] contact_y;
    normal_e              normal_code;
  } res_t;

  // Data that rides alongside the dividers.
  typedef struct packed {
    logic                 zero_vel;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [NW-1:0] ox2;
    logic signed [NW-1:0] oy2;
  } side_t;

  // Slab decision handed to the contact stages.
  typedef struct packed {
    logic                 hit;
    normal_e              normal;
    logic signed [CW-1:0] et;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [NW-1:0] ox2;
    logic signed [NW-1:0] oy2;
  } slab_t;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    begin
      if (v > SAT_HI) r = SAT_HI;
      else if (v < SAT_LO) r = SAT_LO;
      else r = v;
      return r[CW-1:0];
    end
  endfunction

endpackage

// File: hdl/sac_div.sv
// Pipelined signed fixed-point divider, num * 2^FB / den; a zero divisor gives signed infinity.
module sac_div (
  input  logic                          clk_i,
  input  logic signed [sac_pkg::NW-1:0] num_i,
  input  logic signed [sac_pkg::CW-1:0] den_i,
  output logic signed [sac_pkg::TW-1:0] quo_o,
  output logic                          bad_o
);
  import sac_pkg::*;

  typedef struct packed {
    logic [CW-1:0]  dmag;
    logic [CW-1:0]  rem;
    logic [DWP-1:0] dq;
    logic           qneg;
    logic           dz;
    logic           nz;
    logic           npos;
  } dstage_t;

  dstage_t st_q [DIV_STAGES+1];
  dstage_t st0_d;
  logic [NW-2:0] nmag;
  logic [CW-1:0] dmag;

  // Restoring division, DIV_BITS quotient bits.
  function automatic dstage_t div_step(input dstage_t s);
    dstage_t       r;
    logic [CW-1:0] tmp;
    begin
      r = s;
      for (int k = 0; k < DIV_BITS; k++) begin
        tmp  = {r.rem[CW-2:0], r.dq[DWP-1]};
        r.dq = {r.dq[DWP-2:0], 1'b0};
        if (tmp >= r.dmag) begin
          r.rem   = tmp - r.dmag;
          r.dq[0] = 1'b1;
        end else begin
          r.rem = tmp;
        end
      end
      return r;
    end
  endfunction

  always_comb begin
    nmag = num_i[NW-1] ? (NW-1)'(-num_i) : num_i[NW-2:0];
    dmag = den_i[CW-1] ? (~den_i + 1'b1) : den_i;
    st0_d.dmag = dmag;
    st0_d.rem  = '0;
    st0_d.dq   = {{(DWP-DW){1'b0}}, nmag, {FB{1'b0}}};
    st0_d.qneg = num_i[NW-1] ^ den_i[CW-1];
    st0_d.dz   = (den_i == '0);
    st0_d.nz   = (num_i == '0);
    st0_d.npos = !num_i[NW-1];
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= st0_d;
    for (int s = 0; s < DIV_STAGES; s++) begin
      st_q[s+1] <= div_step(st_q[s]);
    end
  end

  // Apply sign; a zero divisor gives signed infinity, zero over zero is bad.
  always_ff @(posedge clk_i) begin
    if (st_q[DIV_STAGES].dz) begin
      quo_o <= st_q[DIV_STAGES].npos ? T_INF : -T_INF;
      bad_o <= st_q[DIV_STAGES].nz;
    end else begin
      quo_o <= st_q[DIV_STAGES].qneg ? -$signed({2'b00, st_q[DIV_STAGES].dq[DW-1:0]})
                                     :  $signed({2'b00, st_q[DIV_STAGES].dq[DW-1:0]});
      bad_o <= 1'b0;
    end
  end

endmodule

// File: hdl/sac_slab.sv
// Slab ordering, overlap tests, entry time and face normal (two stages).
module sac_slab (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [sac_pkg::TW-1:0] nx_i,
  input  logic signed [sac_pkg::TW-1:0] fx_i,
  input  logic signed [sac_pkg::TW-1:0] ny_i,
  input  logic signed [sac_pkg::TW-1:0] fy_i,
  input  logic                          bad_i,
  input  sac_pkg::side_t                side_i,
  output logic                          valid_o,
  output sac_pkg::slab_t                slab_o
);
  import sac_pkg::*;

  logic signed [TW-1:0] a_nx_d, a_fx_d, a_ny_d, a_fy_d;
  logic signed [TW-1:0] a_nx_q, a_fx_q, a_ny_q, a_fy_q;
  logic                 a_kill_d, a_kill_q, a_valid_q;
  side_t                a_side_q;
  logic signed [TW-1:0] tn, tf;
  slab_t                b_d;

  always_comb begin
    a_nx_d   = (nx_i > fx_i) ? fx_i : nx_i;
    a_fx_d   = (nx_i > fx_i) ? nx_i : fx_i;
    a_ny_d   = (ny_i > fy_i) ? fy_i : ny_i;
    a_fy_d   = (ny_i > fy_i) ? ny_i : fy_i;
    a_kill_d = bad_i || side_i.zero_vel || (a_nx_d > a_fy_d) || (a_ny_d > a_fx_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_nx_q   <= a_nx_d;
    a_fx_q   <= a_fx_d;
    a_ny_q   <= a_ny_d;
    a_fy_q   <= a_fy_d;
    a_kill_q <= a_kill_d;
    a_side_q <= side_i;
  end

  always_comb begin
    tn = (a_nx_q > a_ny_q) ? a_nx_q : a_ny_q;
    tf = (a_fx_q < a_fy_q) ? a_fx_q : a_fy_q;
    b_d.hit = !(a_kill_q || (tf < 0) || (tn > T_ONE));
    b_d.et  = sat_cw(SW'(tn));
    if (a_nx_q > a_ny_q) b_d.normal = a_side_q.vx[CW-1] ? NORM_PX : NORM_MX;
    else if (a_nx_q < a_ny_q) b_d.normal = a_side_q.vy[CW-1] ? NORM_PY : NORM_MY;
    else b_d.normal = NORM_NONE;
    b_d.vx  = a_side_q.vx;
    b_d.vy  = a_side_q.vy;
    b_d.ox2 = a_side_q.ox2;
    b_d.oy2 = a_side_q.oy2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    slab_o <= b_d;
  end

endmodule

// File: hdl/sac_contact.sv
// Contact point: multiply stage, then add, floor shift and saturate.
module sac_contact (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  sac_pkg::slab_t slab_i,
  output logic           valid_o,
  output sac_pkg::res_t  res_o
);
  import sac_pkg::*;

  logic signed [2*CW-1:0] px_q, py_q;
  slab_t                  c_q;
  logic                   c_valid_q;
  logic signed [SW-1:0]   sx, sy;
  res_t                   res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else begin
      c_valid_q <= valid_i;
      valid_o   <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= slab_i.et * slab_i.vx;
    py_q <= slab_i.et * slab_i.vy;
    c_q  <= slab_i;
  end

  always_comb begin
    sx = (SW'(c_q.ox2) <<< (FB - 1)) + SW'(px_q);
    sy = (SW'(c_q.oy2) <<< (FB - 1)) + SW'(py_q);
    res_d = '0;
    if (c_q.hit) begin
      res_d.hit         = 1'b1;
      res_d.entry_time  = c_q.et;
      res_d.contact_x   = sat_cw(sx >>> FB);
      res_d.contact_y   = sat_cw(sy >>> FB);
      res_d.normal_code = c_q.normal;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

endmodule

// File: hdl/swept_aabb_collision.sv
// Top level of the swept box versus fixed box collision pipeline.
//
// Swept box collision engine. Each transaction is one moving box, its step
// displacement and one fixed box, all signed Q4.12. A transaction is taken at
// every clock edge with start_i high; busy_o stays low, so one pair can enter
// every cycle. The result appears on res_o with done_o high for exactly one
// cycle, in the order the pairs entered; the receiver cannot hold it off.
// The four slab dividers run side by side: eight stages of four restoring
// quotient bits each, plus a setup and a sign stage. Around them sit an
// input register, two slab decision stages, a multiply stage and a final
// add/saturate stage. No state is kept between transactions. A miss reports
// hit 0 with all other fields 0.
module swept_aabb_collision (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  sac_pkg::req_t req_i,
  output logic          done_o,
  output sac_pkg::res_t res_o
);
  import sac_pkg::*;

  req_t                 in_q;
  logic                 in_valid_q;
  logic signed [NW-1:0] ml, mt, mr, mb, ol, ot, orr, ob, sx, sy, dxw, dyw;
  logic signed [NW-1:0] num_nx, num_fx, num_ny, num_fy;
  side_t                side_d;
  side_t                side_q  [DIV_LAT];
  logic                 valid_q [DIV_LAT];
  logic signed [TW-1:0] t_nx, t_fx, t_ny, t_fy;
  logic                 bad_nx, bad_fx, bad_ny, bad_fy;
  logic                 slab_valid;
  slab_t                slab;

  // Never stall: the pipeline moves every cycle.
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= req_i;
  end

  // Grow the obstacle by the mover's size and form exact slab numerators.
  always_comb begin
    ml  = NW'(in_q.mover_left);
    mt  = NW'(in_q.mover_top);
    mr  = NW'(in_q.mover_right);
    mb  = NW'(in_q.mover_bottom);
    ol  = NW'(in_q.obstacle_left);
    ot  = NW'(in_q.obstacle_top);
    orr = NW'(in_q.obstacle_right);
    ob  = NW'(in_q.obstacle_bottom);
    dxw = mr - ml;
    dyw = mt - mb;
    sx  = dxw[NW-1] ? -dxw : dxw;
    sy  = dyw[NW-1] ? -dyw : dyw;
    num_nx = ol - ml - sx;
    num_fx = orr - ml;
    num_ny = ot - mt + sy;
    num_fy = ob - mt;
    side_d.zero_vel = (in_q.vel_x == '0) && (in_q.vel_y == '0);
    side_d.vx  = in_q.vel_x;
    side_d.vy  = in_q.vel_y;
    side_d.ox2 = (ml <<< 1) + sx;
    side_d.oy2 = (mt <<< 1) - sy;
  end

  sac_div u_div_nx (.clk_i, .num_i(num_nx), .den_i(in_q.vel_x), .quo_o(t_nx), .bad_o(bad_nx));
  sac_div u_div_fx (.clk_i, .num_i(num_fx), .den_i(in_q.vel_x), .quo_o(t_fx), .bad_o(bad_fx));
  sac_div u_div_ny (.clk_i, .num_i(num_ny), .den_i(in_q.vel_y), .quo_o(t_ny), .bad_o(bad_ny));
  sac_div u_div_fy (.clk_i, .num_i(num_fy), .den_i(in_q.vel_y), .quo_o(t_fy), .bad_o(bad_fy));

  // Carry valid and sideband alongside the dividers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) valid_q[i] <= 1'b0;
    end else begin
      valid_q[0] <= in_valid_q;
      for (int i = 1; i < DIV_LAT; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < DIV_LAT; i++) side_q[i] <= side_q[i-1];
  end

  sac_slab u_slab (
    .clk_i,
    .rst_ni,
    .valid_i (valid_q[DIV_LAT-1]),
    .nx_i    (t_nx),
    .fx_i    (t_fx),
    .ny_i    (t_ny),
    .fy_i    (t_fy),
    .bad_i   (bad_nx || bad_fx || bad_ny || bad_fy),
    .side_i  (side_q[DIV_LAT-1]),
    .valid_o (slab_valid),
    .slab_o  (slab)
  );

  sac_contact u_contact (
    .clk_i,
    .rst_ni,
    .valid_i (slab_valid),
    .slab_i  (slab),
    .valid_o (done_o),
    .res_o
  );

  // Every accepted transaction comes out as a result on done_o.
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##PIPE_LAT done_o) else $error("result missing after start");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, PIPE_LAT)) else $error("result without start");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.hit |-> res_o.entry_time == '0 && res_o.contact_x == '0
                             && res_o.contact_y == '0 && res_o.normal_code == NORM_NONE)
    else $error("miss with nonzero fields");

  a_hit_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.hit |-> res_o.entry_time <= $signed(T_ONE[CW-1:0]))
    else $error("hit later than one step");

endmodule
